[rtl/ldss_pkg.sv]
// Shared types and constants for the LED display serial command sequencer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ldss_pkg;

  localparam int unsigned GRID_W = 5;

  typedef enum logic [1:0] {
    OP_FRAME  = 2'd0,
    OP_ON     = 2'd1,
    OP_OFF    = 2'd2,
    OP_BRIGHT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SYM_START  = 2'd0,
    SYM_BYTE   = 2'd1,
    SYM_STOP   = 2'd2,
    SYM_REJECT = 2'd3
  } sym_kind_t;

  localparam logic [7:0] CMD_WRITE_MODE = 8'h40;
  localparam logic [7:0] CMD_ADDR_FIRST = 8'hC0;
  localparam logic [7:0] CMD_SHOW       = 8'h88;
  localparam logic [7:0] CMD_BLANK      = 8'h80;
  localparam logic [7:0] PAD_BYTE       = 8'h00;
  localparam logic [2:0] BRIGHT_MAX     = 3'd7;

  // One classified request, as handed from the front end to the back end.
  typedef struct packed {
    logic              header;
    logic              pix_en;
    logic [7:0]        pix;
    logic [GRID_W-1:0] pad;
    logic              close;
    logic              ctrl;
    logic [7:0]        cmd;
    logic              reject;
  } job_t;

endpackage

[rtl/ldss_if.sv]
// Valid/ready channel interfaces for requests and bus symbols.
// Depends on ldss_pkg for the field types.
`timescale 1ns / 1ps

interface ldss_req_if import ldss_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] pixel_byte;
  logic       frame_end;
  logic [7:0] level;

  modport source (output valid, op, pixel_byte, frame_end, level, input ready);
  modport sink   (input valid, op, pixel_byte, frame_end, level, output ready);
endinterface

interface ldss_sym_if import ldss_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic       run_end;

  modport source (output valid, kind, value, run_end, input ready);
  modport sink   (input valid, kind, value, run_end, output ready);
endinterface

[rtl/led_display_serial_command_sequencer.sv]
// Usage notes
// Requests arrive on the req channel (op, pixel_byte, frame_end, level) and
// bus symbols leave on the sym channel (kind, value, run_end); both are
// valid/ready channels and a transaction completes when valid and ready are
// high at a rising clock edge.
// The front end classifies each request in the cycle it is accepted and
// places a job in a two-entry queue, so req stays ready while that queue has
// room. The back end takes one job per pass: it loads the job while idle,
// then emits one symbol per cycle while sym is not stalled. The first symbol
// of a request passes through the queue, the job load and the output
// register; the longest request is a 25-symbol frame close, and the output
// register paces everything when the receiver stalls.
// Requests that cause no symbols use no queue entry.
// Synchronous reset returns brightness to seven, the display to off, closes
// any open frame and empties the queue and the output stage.
// Depends on ldss_pkg, ldss_if, ldss_front, ldss_queue and ldss_back.
`timescale 1ns / 1ps

module led_display_serial_command_sequencer import ldss_pkg::*; #(
  parameter int unsigned GRIDS = 16
) (
  input  logic       clk,
  input  logic       rst,
  ldss_req_if.sink   req,
  ldss_sym_if.source sym
);

  logic push, q_full, pop, q_valid;
  job_t push_job, q_job;

  ldss_front #(.GRIDS(GRIDS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  ldss_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  ldss_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (q_job),
    .pop     (pop),
    .sym     (sym)
  );

endmodule

[rtl/ldss_front.sv]
// Front end: accepts requests, keeps display and frame state, and turns each
// request into a job descriptor. Depends on ldss_pkg and ldss_if.
`timescale 1ns / 1ps

module ldss_front import ldss_pkg::*; #(
  parameter int unsigned GRIDS = 16
) (
  input  logic            clk,
  input  logic            rst,
  ldss_req_if.sink        req,
  input  logic            q_full,
  output logic            push,
  output job_t            push_job
);

  localparam logic [GRID_W-1:0] GridsC = GRID_W'(GRIDS);

  logic [2:0]        bright_level, bright_level_next;
  logic              shown, shown_next;
  logic              in_frame, in_frame_next;
  logic [GRID_W-1:0] grid_count, grid_count_next;

  logic              accept;
  logic              want_push;
  logic [GRID_W-1:0] g0, g1;
  logic [7:0]        show_cmd;

  assign req.ready = !q_full;
  assign accept    = req.valid && req.ready;
  assign push      = accept && want_push;
  assign show_cmd  = CMD_SHOW | {5'd0, bright_level};

  always_comb begin
    bright_level_next = bright_level;
    shown_next        = shown;
    in_frame_next     = in_frame;
    grid_count_next   = grid_count;
    want_push         = 1'b0;
    push_job          = '0;
    g0                = in_frame ? grid_count : '0;
    g1                = g0;
    unique case (op_t'(req.op))
      OP_FRAME: begin
        push_job.header = !in_frame;
        push_job.pix_en = g0 < GridsC;
        push_job.pix    = req.pixel_byte;
        g1 = push_job.pix_en ? g0 + GRID_W'(1) : g0;
        if (req.frame_end) begin
          push_job.pad   = GridsC - g1;
          push_job.close = 1'b1;
          push_job.ctrl  = 1'b1;
          push_job.cmd   = shown ? show_cmd : CMD_BLANK;
          in_frame_next   = 1'b0;
          grid_count_next = '0;
        end else begin
          in_frame_next   = 1'b1;
          grid_count_next = g1;
        end
        want_push = push_job.pix_en || req.frame_end;
      end
      OP_ON: begin
        shown_next    = 1'b1;
        push_job.ctrl = 1'b1;
        push_job.cmd  = show_cmd;
        want_push     = 1'b1;
      end
      OP_OFF: begin
        shown_next    = 1'b0;
        push_job.ctrl = 1'b1;
        push_job.cmd  = CMD_BLANK;
        want_push     = 1'b1;
      end
      OP_BRIGHT: begin
        if (req.level > {5'd0, BRIGHT_MAX}) begin
          push_job.reject = 1'b1;
          want_push       = 1'b1;
        end else begin
          bright_level_next = req.level[2:0];
          push_job.ctrl     = 1'b1;
          push_job.cmd      = CMD_SHOW | {5'd0, req.level[2:0]};
          want_push         = shown;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bright_level <= BRIGHT_MAX;
      shown        <= 1'b0;
      in_frame     <= 1'b0;
      grid_count   <= '0;
    end else if (accept) begin
      bright_level <= bright_level_next;
      shown        <= shown_next;
      in_frame     <= in_frame_next;
      grid_count   <= grid_count_next;
    end
  end

endmodule

[rtl/ldss_queue.sv]
// Two-entry job queue between the front end and the symbol generator.
// Depends on ldss_pkg for the job descriptor.
`timescale 1ns / 1ps

module ldss_queue import ldss_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output job_t q_job
);

  job_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full    = count == 2'd2;
  assign q_valid = count != 2'd0;
  assign q_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("job popped from an empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue occupancy out of range");

endmodule

[rtl/ldss_back.sv]
// Back end: steps through one job at a time and emits its bus symbols into
// a registered output stage. Depends on ldss_pkg and ldss_if.
`timescale 1ns / 1ps

module ldss_back import ldss_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  job_t       q_job,
  output logic       pop,
  ldss_sym_if.source sym
);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_HDR    = 4'd1,
    PH_PIX    = 4'd2,
    PH_PAD    = 4'd3,
    PH_STOP   = 4'd4,
    PH_CSTART = 4'd5,
    PH_CBYTE  = 4'd6,
    PH_CSTOP  = 4'd7,
    PH_REJ    = 4'd8
  } phase_t;

  phase_t            phase, phase_next;
  job_t              job;
  logic [2:0]        hdr_idx;
  logic [GRID_W-1:0] pad_left;
  logic              out_free;
  sym_kind_t         kind_next;
  logic [7:0]        value_next;

  // First phase at or after 'from' that the job actually needs.
  function automatic phase_t first_from(input phase_t from, input job_t j);
    phase_t r;
    priority if (from <= PH_HDR && j.header) r = PH_HDR;
    else if (from <= PH_PIX && j.pix_en) r = PH_PIX;
    else if (from <= PH_PAD && j.pad != '0) r = PH_PAD;
    else if (from <= PH_STOP && j.close) r = PH_STOP;
    else if (from <= PH_CSTART && j.ctrl) r = PH_CSTART;
    else if (from <= PH_REJ && j.reject) r = PH_REJ;
    else r = PH_IDLE;
    return r;
  endfunction

  assign out_free = !sym.valid || sym.ready;
  assign pop      = phase == PH_IDLE && q_valid;

  always_comb begin
    kind_next  = SYM_START;
    value_next = 8'h00;
    phase_next = PH_IDLE;
    unique case (phase)
      PH_IDLE: phase_next = PH_IDLE;
      PH_HDR: begin
        unique case (hdr_idx)
          3'd1: begin kind_next = SYM_BYTE; value_next = CMD_WRITE_MODE; end
          3'd2: kind_next = SYM_STOP;
          3'd4: begin kind_next = SYM_BYTE; value_next = CMD_ADDR_FIRST; end
          default: kind_next = SYM_START;
        endcase
        phase_next = (hdr_idx == 3'd4) ? first_from(PH_PIX, job) : PH_HDR;
      end
      PH_PIX: begin
        kind_next  = SYM_BYTE;
        value_next = job.pix;
        phase_next = first_from(PH_PAD, job);
      end
      PH_PAD: begin
        kind_next  = SYM_BYTE;
        value_next = PAD_BYTE;
        phase_next = (pad_left == GRID_W'(1)) ? first_from(PH_STOP, job) : PH_PAD;
      end
      PH_STOP: begin
        kind_next  = SYM_STOP;
        phase_next = first_from(PH_CSTART, job);
      end
      PH_CSTART: phase_next = PH_CBYTE;
      PH_CBYTE: begin
        kind_next  = SYM_BYTE;
        value_next = job.cmd;
        phase_next = PH_CSTOP;
      end
      PH_CSTOP: begin
        kind_next  = SYM_STOP;
        phase_next = first_from(PH_REJ, job);
      end
      PH_REJ: begin
        kind_next  = SYM_REJECT;
        phase_next = PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      sym.valid <= 1'b0;
      hdr_idx   <= 3'd0;
      pad_left  <= '0;
    end else begin
      // A job is only loaded while idle, so the two branches below never
      // update the same register in one cycle.
      if (phase != PH_IDLE && out_free) begin
        sym.valid   <= 1'b1;
        sym.kind    <= kind_next;
        sym.value   <= value_next;
        sym.run_end <= phase_next == PH_IDLE;
        phase       <= phase_next;
        if (phase == PH_HDR) begin
          hdr_idx <= hdr_idx + 3'd1;
        end
        if (phase == PH_PAD) begin
          pad_left <= pad_left - GRID_W'(1);
        end
      end else if (sym.ready) begin
        sym.valid <= 1'b0;
      end
      if (pop) begin
        job      <= q_job;
        pad_left <= q_job.pad;
        hdr_idx  <= 3'd0;
        phase    <= first_from(PH_HDR, q_job);
      end
    end
  end

  a_reject_alone: assert property (@(posedge clk) disable iff (rst)
      sym.valid && sym.kind == SYM_REJECT |-> sym.run_end && sym.value == 8'h00)
    else $error("rejection symbol not a lone final symbol");
  a_value_only_bytes: assert property (@(posedge clk) disable iff (rst)
      sym.valid && sym.kind != SYM_BYTE |-> sym.value == 8'h00)
    else $error("non-byte symbol carries a value");
  a_pad_counts_down: assert property (@(posedge clk) disable iff (rst)
      phase == PH_PAD |-> pad_left != '0)
    else $error("padding phase with nothing left to pad");

endmodule
